@@ rtl/core/r2h_pkg.sv @@
// shared types, constants and the divider step for the rgb to hsv converter
`timescale 1ns / 1ps

package r2h_pkg;

    // field widths
    localparam int CH_W  = 8;
    localparam int HUE_W = 15;
    // quotient bits per division, one pipeline stage per bit
    localparam int QUO_W = 12;
    // numerator width, high part stays below the divisor
    localparam int NUM_W = CH_W + QUO_W;

    // hue in degrees times 64
    localparam logic [HUE_W-1:0] HUE_FULL_TURN  = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 15'd15360;

    // which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // sideband that travels next to the division
    typedef struct packed {
        t_sector           sector;
        logic              neg;
        logic              grey;
        logic [CH_W-1:0]   hi;
    } t_side;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [CH_W:0] f_div_step(
        input logic [CH_W-1:0] rem,
        input logic            nb,
        input logic [CH_W-1:0] den
    );
        logic [CH_W:0] t;
        logic [CH_W:0] d;
        logic [CH_W:0] s;
        t = {rem, nb};
        d = {1'b0, den};
        s = t - d;
        if (t >= d) begin
            return {1'b1, s[CH_W-1:0]};
        end
        return {1'b0, t[CH_W-1:0]};
    endfunction

endpackage

@@ rtl/core/r2h_divpipe.sv @@
// pipelined restoring dividers for hue and saturation, one quotient bit per stage
`timescale 1ns / 1ps

module r2h_divpipe (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [r2h_pkg::NUM_W-1:0]    i_hue_num,
    input  logic [r2h_pkg::CH_W-1:0]     i_hue_den,
    input  logic [r2h_pkg::NUM_W-1:0]    i_sat_num,
    input  logic [r2h_pkg::CH_W-1:0]     i_sat_den,
    input  r2h_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [r2h_pkg::QUO_W-1:0]    o_hue_quo,
    output logic                         o_hue_rem_nz,
    output logic [r2h_pkg::QUO_W-1:0]    o_sat_quo,
    output r2h_pkg::t_side               o_side
);
    import r2h_pkg::*;

    // stage registers, one entry per quotient bit
    logic              r_valid [QUO_W];
    t_side             r_side  [QUO_W];
    logic [CH_W-1:0]   r_hden  [QUO_W];
    logic [CH_W-1:0]   r_hrem  [QUO_W];
    logic [QUO_W-1:0]  r_hlow  [QUO_W];
    logic [QUO_W-1:0]  r_hquo  [QUO_W];
    logic [CH_W-1:0]   r_sden  [QUO_W];
    logic [CH_W-1:0]   r_srem  [QUO_W];
    logic [QUO_W-1:0]  r_slow  [QUO_W];
    logic [QUO_W-1:0]  r_squo  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              p_valid;
        t_side             p_side;
        logic [CH_W-1:0]   p_hden;
        logic [CH_W-1:0]   p_hrem;
        logic [QUO_W-1:0]  p_hlow;
        logic [QUO_W-1:0]  p_hquo;
        logic [CH_W-1:0]   p_sden;
        logic [CH_W-1:0]   p_srem;
        logic [QUO_W-1:0]  p_slow;
        logic [QUO_W-1:0]  p_squo;
        logic [CH_W:0]     n_hstep;
        logic [CH_W:0]     n_sstep;

        // stage input: the ports for the first stage, else the stage before
        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_side  = i_side;
            assign p_hden  = i_hue_den;
            assign p_hrem  = i_hue_num[NUM_W-1:QUO_W];
            assign p_hlow  = i_hue_num[QUO_W-1:0];
            assign p_hquo  = '0;
            assign p_sden  = i_sat_den;
            assign p_srem  = i_sat_num[NUM_W-1:QUO_W];
            assign p_slow  = i_sat_num[QUO_W-1:0];
            assign p_squo  = '0;
        end else begin : g_next
            assign p_valid = r_valid[k-1];
            assign p_side  = r_side[k-1];
            assign p_hden  = r_hden[k-1];
            assign p_hrem  = r_hrem[k-1];
            assign p_hlow  = r_hlow[k-1];
            assign p_hquo  = r_hquo[k-1];
            assign p_sden  = r_sden[k-1];
            assign p_srem  = r_srem[k-1];
            assign p_slow  = r_slow[k-1];
            assign p_squo  = r_squo[k-1];
        end

        // one compare and subtract per lane
        assign n_hstep = f_div_step(p_hrem, p_hlow[QUO_W-1], p_hden);
        assign n_sstep = f_div_step(p_srem, p_slow[QUO_W-1], p_sden);

        // valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= p_valid;
            end
        end

        // payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= p_side;
                r_hden[k] <= p_hden;
                r_hrem[k] <= n_hstep[CH_W-1:0];
                r_hlow[k] <= {p_hlow[QUO_W-2:0], 1'b0};
                r_hquo[k] <= {p_hquo[QUO_W-2:0], n_hstep[CH_W]};
                r_sden[k] <= p_sden;
                r_srem[k] <= n_sstep[CH_W-1:0];
                r_slow[k] <= {p_slow[QUO_W-2:0], 1'b0};
                r_squo[k] <= {p_squo[QUO_W-2:0], n_sstep[CH_W]};
            end
        end
    end

    // last stage out
    assign o_valid      = r_valid[QUO_W-1];
    assign o_side       = r_side[QUO_W-1];
    assign o_hue_quo    = r_hquo[QUO_W-1];
    assign o_hue_rem_nz = |r_hrem[QUO_W-1];
    assign o_sat_quo    = r_squo[QUO_W-1];

endmodule

@@ rtl/core/rgb_to_hsv.sv @@
// rgb to hexcone hsv converter, fixed point, fully pipelined
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   pixel   | i_valid, o_ready, i_red/green/blue       | in
//   hsv     | o_valid, i_ready, o_hue, o_saturation,   | out
//           | o_brightness, o_is_grey                  |
//
// one pixel per clock sustained while the output is not stalled; two stages for
// max/min and numerators, twelve for the bit-serial dividers (one quotient
// bit per stage), one for the hue fix-up and output register.
// synchronous active-low reset clears the valid bits only.
// a stall at the output freezes the whole pipeline; o_ready is low only
// while the output register holds a transaction that is not being taken.
`timescale 1ns / 1ps

module rgb_to_hsv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [r2h_pkg::CH_W-1:0]     i_red,
    input  logic [r2h_pkg::CH_W-1:0]     i_green,
    input  logic [r2h_pkg::CH_W-1:0]     i_blue,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [r2h_pkg::HUE_W-1:0]    o_hue,
    output logic [r2h_pkg::CH_W-1:0]     o_saturation,
    output logic [r2h_pkg::CH_W-1:0]     o_brightness,
    output logic                         o_is_grey
);
    import r2h_pkg::*;

    logic                    en;

    logic                    r_s1_valid;
    logic [CH_W-1:0]         r_s1_hi;
    logic [CH_W-1:0]         r_s1_lo;
    t_sector                 r_s1_sector;
    logic [CH_W:0]           r_s1_diff;
    t_sector                 n_s1_sector;
    logic [CH_W-1:0]         n_s1_hi;
    logic [CH_W-1:0]         n_s1_lo;
    logic [CH_W:0]           n_s1_diff;

    logic                    r_s2_valid;
    logic [NUM_W-1:0]        r_s2_hue_num;
    logic [NUM_W-1:0]        r_s2_sat_num;
    logic [CH_W-1:0]         r_s2_chroma;
    t_side                   r_s2_side;
    logic [CH_W-1:0]         n_s2_chroma;
    logic [CH_W:0]           n_s2_absd;
    logic [NUM_W-1:0]        n_s2_hue_num;
    logic [2*CH_W-1:0]       n_s2_sat_num;

    logic                    div_valid;
    logic [QUO_W-1:0]        div_hue_quo;
    logic                    div_hue_rem_nz;
    logic [QUO_W-1:0]        div_sat_quo;
    t_side                   div_side;

    logic                    r_out_valid;
    logic [HUE_W-1:0]        r_out_hue;
    logic [CH_W-1:0]         r_out_sat;
    logic [CH_W-1:0]         r_out_val;
    logic                    r_out_grey;
    logic [HUE_W-1:0]        n_out_hue;
    logic [HUE_W-1:0]        hue_q;
    logic [HUE_W-1:0]        hue_base;

    // whole pipeline moves when the output slot is free or being taken
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    // stage 1: max, min, sector and signed channel difference
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_s1_sector = SEC_RED;
            n_s1_hi     = i_red;
            n_s1_diff   = {1'b0, i_green} - {1'b0, i_blue};
        end else if (i_green >= i_blue) begin
            n_s1_sector = SEC_GREEN;
            n_s1_hi     = i_green;
            n_s1_diff   = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            n_s1_sector = SEC_BLUE;
            n_s1_hi     = i_blue;
            n_s1_diff   = {1'b0, i_red} - {1'b0, i_green};
        end
        if (i_red <= i_green && i_red <= i_blue) begin
            n_s1_lo = i_red;
        end else if (i_green <= i_blue) begin
            n_s1_lo = i_green;
        end else begin
            n_s1_lo = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_hi     <= n_s1_hi;
            r_s1_lo     <= n_s1_lo;
            r_s1_sector <= n_s1_sector;
            r_s1_diff   <= n_s1_diff;
        end
    end

    // stage 2: chroma, |diff|, numerators 3840*|diff| and 255*chroma
    always_comb begin
        n_s2_chroma  = r_s1_hi - r_s1_lo;
        n_s2_absd    = r_s1_diff[CH_W] ? (~r_s1_diff + 1'b1) : r_s1_diff;
        n_s2_hue_num = {n_s2_absd[CH_W-1:0], 12'd0} - {4'd0, n_s2_absd[CH_W-1:0], 8'd0};
        n_s2_sat_num = {n_s2_chroma, 8'd0} - {8'd0, n_s2_chroma};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_hue_num     <= n_s2_hue_num;
            r_s2_sat_num     <= {{(NUM_W-2*CH_W){1'b0}}, n_s2_sat_num};
            r_s2_chroma      <= n_s2_chroma;
            r_s2_side.sector <= r_s1_sector;
            r_s2_side.neg    <= r_s1_diff[CH_W];
            r_s2_side.grey   <= (n_s2_chroma == '0);
            r_s2_side.hi     <= r_s1_hi;
        end
    end

    // dividers: hue fraction over chroma, saturation over value
    r2h_divpipe u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (r_s2_valid),
        .i_hue_num    (r_s2_hue_num),
        .i_hue_den    (r_s2_chroma),
        .i_sat_num    (r_s2_sat_num),
        .i_sat_den    (r_s2_side.hi),
        .i_side       (r_s2_side),
        .o_valid      (div_valid),
        .o_hue_quo    (div_hue_quo),
        .o_hue_rem_nz (div_hue_rem_nz),
        .o_sat_quo    (div_sat_quo),
        .o_side       (div_side)
    );

    // hue fix-up: red wraps a negative truncated quotient, others floor
    always_comb begin
        hue_q = {{(HUE_W-QUO_W){1'b0}}, div_hue_quo};
        case (div_side.sector)
            SEC_GREEN: hue_base = HUE_GREEN_BASE;
            SEC_BLUE:  hue_base = HUE_BLUE_BASE;
            default:   hue_base = '0;
        endcase
        if (div_side.grey) begin
            n_out_hue = '0;
        end else if (!div_side.neg) begin
            n_out_hue = hue_base + hue_q;
        end else if (div_side.sector == SEC_RED) begin
            n_out_hue = HUE_FULL_TURN - hue_q;
        end else begin
            n_out_hue = hue_base - hue_q - {{(HUE_W-1){1'b0}}, div_hue_rem_nz};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hue  <= n_out_hue;
            r_out_sat  <= div_side.grey ? '0 : div_sat_quo[CH_W-1:0];
            r_out_val  <= div_side.hi;
            r_out_grey <= div_side.grey;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hue        = r_out_hue;
    assign o_saturation = r_out_sat;
    assign o_brightness = r_out_val;
    assign o_is_grey    = r_out_grey;

`ifndef NO_ASSERTIONS
    // grey pixels carry zero hue and zero saturation
    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_grey) |-> (o_hue == '0 && o_saturation == '0))
        else $error("grey transaction with nonzero hue or saturation");

    // hue stays below a full turn
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < HUE_FULL_TURN))
        else $error("hue out of range");

    // colored pixels always have some saturation
    a_sat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_grey) |-> (o_saturation != '0 && o_brightness != '0))
        else $error("colored transaction with zero saturation");

    // a stalled output freezes the divider pipeline
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> ($stable(div_valid) && $stable(div_hue_quo)))
        else $error("pipeline moved during stall");
`endif

endmodule
